FILE: hw/rtl/lmt_pkg.sv
// ---------------------------------------------------------------------------
// lmt_pkg: shared types and constants for the LCD mode timing block
// Line and frame geometry, mode codes, register indexes and the bundles
// that travel between the configuration, step and top-level modules.
// ---------------------------------------------------------------------------
package lmt_pkg;

  // Input advance width (low bits of cycles_elapsed that are used)
  localparam int ADVANCE_WIDTH = 8;

  // Line geometry in cycles
  localparam int OAM_CYCLES    = 80;
  localparam int XFER_CYCLES   = 172;
  localparam int HBLANK_CYCLES = 204;
  localparam int LINE_CYCLES   = OAM_CYCLES + XFER_CYCLES + HBLANK_CYCLES;

  // Frame geometry in lines
  localparam int VISIBLE_LINES = 144;
  localparam int VBLANK_LINES  = 10;
  localparam int FRAME_LINES   = VISIBLE_LINES + VBLANK_LINES;

  localparam int CYCLE_W = 9;
  localparam int LINE_W  = 8;

  localparam logic [CYCLE_W-1:0] OAM_END   = CYCLE_W'(OAM_CYCLES);
  localparam logic [CYCLE_W-1:0] XFER_END  = CYCLE_W'(OAM_CYCLES + XFER_CYCLES);
  localparam logic [CYCLE_W:0]   LINE_LEN  = (CYCLE_W+1)'(LINE_CYCLES);
  localparam logic [LINE_W-1:0]  VBL_START = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0]  LAST_LINE = LINE_W'(FRAME_LINES - 1);

  // Configuration register indexes
  localparam logic CFG_LINE_COMPARE = 1'b0;
  localparam logic CFG_STAT_ENABLES = 1'b1;

  // STAT enable bit positions
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_COIN   = 3;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] line_compare;
    logic [3:0] stat_irq_enables;
  } cfg_t;

  typedef struct packed {
    mode_t             lcd_mode;
    logic [LINE_W-1:0] current_line;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              line_render_start;
    logic              frame_flip;
  } result_t;

endpackage

FILE: hw/rtl/lmt_cfg.sv
// ---------------------------------------------------------------------------
// lmt_cfg: configuration registers
// Holds the line compare value and the STAT interrupt enables.
// ---------------------------------------------------------------------------
module lmt_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  output lmt_pkg::cfg_t cfg
);

  // always able to take a write
  assign cfg_ready = 1'b1;

  // register write on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_compare     <= '0;
      cfg.stat_irq_enables <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lmt_pkg::CFG_LINE_COMPARE: cfg.line_compare     <= cfg_data;
        lmt_pkg::CFG_STAT_ENABLES: cfg.stat_irq_enables <= cfg_data[3:0];
        default:                   cfg.line_compare     <= cfg.line_compare;
      endcase
    end
  end

endmodule

FILE: hw/rtl/lmt_step.sv
// ---------------------------------------------------------------------------
// lmt_step: line / frame position counters and per-step result logic
// Advances the cycle and line counters, derives the mode and raises the
// entry pulses and interrupt requests for one step.
// ---------------------------------------------------------------------------
module lmt_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step_en,
  input  logic [lmt_pkg::ADVANCE_WIDTH-1:0] adv,
  input  lmt_pkg::cfg_t                     cfg,
  output lmt_pkg::result_t                  res
);

  logic [lmt_pkg::CYCLE_W-1:0] line_cycle, line_cycle_next;
  logic [lmt_pkg::LINE_W-1:0]  line_counter, line_counter_next;
  lmt_pkg::mode_t              previous_mode, mode_next;
  logic [lmt_pkg::CYCLE_W:0]   sum;
  logic                        wrap;
  logic                        entered;
  logic                        coin;

  // cycle advance, one line boundary at most
  assign sum  = {1'b0, line_cycle} + (lmt_pkg::CYCLE_W+1)'(adv);
  assign wrap = (sum >= lmt_pkg::LINE_LEN);

  always_comb begin
    line_cycle_next   = wrap ? lmt_pkg::CYCLE_W'(sum - lmt_pkg::LINE_LEN)
                             : sum[lmt_pkg::CYCLE_W-1:0];
    line_counter_next = line_counter;
    if (wrap) begin
      line_counter_next = (line_counter == lmt_pkg::LAST_LINE) ? '0
                          : line_counter + 8'd1;
    end
  end

  // mode from new position
  always_comb begin
    if (line_counter_next >= lmt_pkg::VBL_START) begin
      mode_next = lmt_pkg::MODE_VBLANK;
    end else if (line_cycle_next < lmt_pkg::OAM_END) begin
      mode_next = lmt_pkg::MODE_OAM;
    end else if (line_cycle_next < lmt_pkg::XFER_END) begin
      mode_next = lmt_pkg::MODE_XFER;
    end else begin
      mode_next = lmt_pkg::MODE_HBLANK;
    end
  end

  // entry pulses and interrupt requests
  assign entered = (mode_next != previous_mode);
  assign coin    = (line_counter_next == cfg.line_compare);

  always_comb begin
    res.lcd_mode          = mode_next;
    res.current_line      = line_counter_next;
    res.coincidence       = coin;
    res.vblank_irq        = entered && (mode_next == lmt_pkg::MODE_VBLANK);
    res.frame_flip        = res.vblank_irq;
    res.line_render_start = entered && (mode_next == lmt_pkg::MODE_XFER);
    res.stat_irq          = coin && cfg.stat_irq_enables[lmt_pkg::EN_COIN];
    if (entered) begin
      unique case (mode_next)
        lmt_pkg::MODE_HBLANK:
          if (cfg.stat_irq_enables[lmt_pkg::EN_HBLANK]) res.stat_irq = 1'b1;
        lmt_pkg::MODE_VBLANK:
          if (cfg.stat_irq_enables[lmt_pkg::EN_VBLANK]) res.stat_irq = 1'b1;
        lmt_pkg::MODE_OAM:
          if (cfg.stat_irq_enables[lmt_pkg::EN_OAM]) res.stat_irq = 1'b1;
        default: ;
      endcase
    end
  end

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_cycle    <= '0;
      line_counter  <= lmt_pkg::VBL_START;
      previous_mode <= lmt_pkg::MODE_HBLANK;
    end else if (step_en) begin
      line_cycle    <= line_cycle_next;
      line_counter  <= line_counter_next;
      previous_mode <= mode_next;
    end
  end

endmodule

FILE: hw/rtl/lcd_mode_timing_and_stat_irq.sv
// ---------------------------------------------------------------------------
// lcd_mode_timing_and_stat_irq: LCD mode timing and STAT interrupt generator
// Tracks the position in a line and a 154-line frame, and per
// step reports mode, line, coincidence and interrupt / event pulses.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  input    | in        | in_valid/in_stall  | cycles_elapsed
//  result   | out       | out_valid/out_stall| lcd_mode, current_line, flags
//  config   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item per clock sustained while out_stall is low; each item passes
//  through the input register, then the result register, whose contents
//  are the presented result.
//  Rate is set by the single counter-add / compare step between the two
//  registers, which updates the position state once per item.
//  Reset (rst, synchronous) puts the position at cycle 0 of line 144.
//  out_stall holds the result register; the input register keeps taking
//  items while it is empty or the result register is free or being drained.
//
module lcd_mode_timing_and_stat_irq (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] cycles_elapsed,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] lcd_mode,
  output logic [7:0] current_line,
  output logic       coincidence,
  output logic       vblank_irq,
  output logic       stat_irq,
  output logic       line_render_start,
  output logic       frame_flip,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  lmt_pkg::cfg_t                     cfg;
  lmt_pkg::result_t                  step_res;
  lmt_pkg::result_t                  res;
  logic                              in_reg_valid;
  logic [lmt_pkg::ADVANCE_WIDTH-1:0] in_reg_adv;
  logic                              out_load;
  logic                              step_en;
  logic                              in_xfer;

  // handshake control
  assign out_load = !out_valid || !out_stall;
  assign step_en  = in_reg_valid && out_load;
  assign in_stall = in_reg_valid && !out_load;
  assign in_xfer  = in_valid && !in_stall;

  lmt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmt_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .adv     (in_reg_adv),
    .cfg     (cfg),
    .res     (step_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else begin
      in_reg_valid <= in_xfer || (in_reg_valid && !step_en);
    end
    if (in_xfer) begin
      in_reg_adv <= cycles_elapsed[lmt_pkg::ADVANCE_WIDTH-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_reg_valid;
    end
    if (step_en) begin
      res <= step_res;
    end
  end

  assign lcd_mode          = res.lcd_mode;
  assign current_line      = res.current_line;
  assign coincidence       = res.coincidence;
  assign vblank_irq        = res.vblank_irq;
  assign stat_irq          = res.stat_irq;
  assign line_render_start = res.line_render_start;
  assign frame_flip        = res.frame_flip;

  // checks
  a_vbl_mode : assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |-> lcd_mode == lmt_pkg::MODE_VBLANK)
    else $error("vblank_irq outside vblank mode");

  a_render_mode : assert property (@(posedge clk) disable iff (rst)
    out_valid && line_render_start |-> lcd_mode == lmt_pkg::MODE_XFER)
    else $error("line_render_start outside data transfer");

  a_line_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> current_line <= lmt_pkg::LAST_LINE)
    else $error("current_line out of frame");

  a_vbl_lines : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lcd_mode == lmt_pkg::MODE_VBLANK) ==
                  (current_line >= lmt_pkg::VBL_START))
    else $error("vblank mode does not match line");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench for lcd_mode_timing_and_stat_irq
// Feeds step sizes through the valid/stall input channel and predicts mode,
// line, coincidence and interrupt pulses from an independent scan-position
// tracker. Results are checked in order under random gaps and stalls.
// ---------------------------------------------------------------------------
module tb;

  // Scan geometry for the tracker
  localparam int SCAN_OAM_END     = 80;
  localparam int SCAN_XFER_END    = 252;
  localparam int SCAN_LINE_LEN    = 456;
  localparam int SCAN_VBL_LINE    = 144;
  localparam int SCAN_FRAME_LINES = 154;
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int LONG_HOLD_CYCLES = 64;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] cycles_elapsed = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] lcd_mode;
  logic [7:0] current_line;
  logic       coincidence;
  logic       vblank_irq;
  logic       stat_irq;
  logic       line_render_start;
  logic       frame_flip;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = lmt_pkg::CFG_LINE_COMPARE;
  logic [7:0] cfg_data = 8'd0;

  lcd_mode_timing_and_stat_irq u_top (.*);

  // Scan position and register copies, in reset state
  logic [8:0]      scan_cycle   = 9'd0;
  logic [7:0]      scan_line    = 8'd144;
  lmt_pkg::mode_t  shown_mode   = lmt_pkg::MODE_HBLANK;
  logic [7:0]      lyc_value    = 8'd0;
  logic [3:0]      stat_enables = 4'd0;

  lmt_pkg::result_t status_due[$];
  logic [7:0]       step_queue[$];
  int unsigned      mismatch_count = 0;
  int unsigned      results_seen = 0;
  int unsigned      idle_cycles = 0;
  logic             quiet = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the scan position by one step and work out the status it reports
  function automatic lmt_pkg::result_t advance_scan(input logic [7:0] cycles);
    logic [9:0]       pos;
    lmt_pkg::mode_t   mode_now;
    lmt_pkg::result_t r;
    pos = {1'b0, scan_cycle} + 10'(cycles);
    if (pos >= 10'(SCAN_LINE_LEN)) begin
      pos = pos - 10'(SCAN_LINE_LEN);
      scan_line = (scan_line == 8'(SCAN_FRAME_LINES - 1)) ? 8'd0 : scan_line + 8'd1;
    end
    scan_cycle = pos[8:0];
    if (scan_line >= 8'(SCAN_VBL_LINE))
      mode_now = lmt_pkg::MODE_VBLANK;
    else if (scan_cycle < 9'(SCAN_OAM_END))
      mode_now = lmt_pkg::MODE_OAM;
    else if (scan_cycle < 9'(SCAN_XFER_END))
      mode_now = lmt_pkg::MODE_XFER;
    else
      mode_now = lmt_pkg::MODE_HBLANK;
    r = '0;
    r.lcd_mode     = mode_now;
    r.current_line = scan_line;
    r.coincidence  = (scan_line == lyc_value);
    // coincidence is a level: raised on every step while enabled
    r.stat_irq     = r.coincidence & stat_enables[lmt_pkg::EN_COIN];
    // any mode change counts as an entry, skipped modes raise nothing
    if (mode_now != shown_mode) begin
      case (mode_now)
        lmt_pkg::MODE_HBLANK: r.stat_irq = r.stat_irq | stat_enables[lmt_pkg::EN_HBLANK];
        lmt_pkg::MODE_VBLANK: begin
          r.vblank_irq = 1'b1;
          r.frame_flip = 1'b1;
          r.stat_irq   = r.stat_irq | stat_enables[lmt_pkg::EN_VBLANK];
        end
        lmt_pkg::MODE_OAM: r.stat_irq = r.stat_irq | stat_enables[lmt_pkg::EN_OAM];
        default: r.line_render_start = 1'b1;
      endcase
    end
    shown_mode = mode_now;
    return r;
  endfunction

  // Step size mix: mostly long steps to get through frames, some tiny ones
  function automatic logic [7:0] random_step();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 10)
      return 8'($urandom_range(128, 255));
    else if (pick < 15)
      return 8'($urandom);
    else if (pick < 18)
      return 8'($urandom_range(0, 7));
    else
      return (pick == 18) ? 8'd0 : 8'd255;
  endfunction

  // Input driver: one step per transfer, random gaps between them
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        status_due.push_back(advance_scan(cycles_elapsed));
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 5);
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (step_queue.size() > 0) begin
          in_valid       <= 1'b1;
          cycles_elapsed <= step_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: in-order check and output stall generation
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    lmt_pkg::result_t seen;
    lmt_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.lcd_mode          = lmt_pkg::mode_t'(lcd_mode);
        seen.current_line      = current_line;
        seen.coincidence       = coincidence;
        seen.vblank_irq        = vblank_irq;
        seen.stat_irq          = stat_irq;
        seen.line_render_start = line_render_start;
        seen.frame_flip        = frame_flip;
        results_seen++;
        // one long hold so the block backs up into its input
        if (results_seen == 150)
          hold_left = LONG_HOLD_CYCLES;
        if (status_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d arrived with nothing pending", results_seen);
        end else begin
          want = status_due.pop_front();
          if (seen.lcd_mode !== want.lcd_mode ||
              seen.current_line !== want.current_line ||
              seen.coincidence !== want.coincidence ||
              seen.vblank_irq !== want.vblank_irq ||
              seen.stat_irq !== want.stat_irq ||
              seen.line_render_start !== want.line_render_start ||
              seen.frame_flip !== want.frame_flip) begin
            mismatch_count++;
            // flags: coin vbl stat render flip
            if (mismatch_count <= 10) begin
              $display("ERROR: result %0d exp mode=%0d line=%0d flags=%b%b%b%b%b",
                       results_seen, want.lcd_mode, want.current_line,
                       want.coincidence, want.vblank_irq, want.stat_irq,
                       want.line_render_start, want.frame_flip);
              $display("       result %0d got mode=%0d line=%0d flags=%b%b%b%b%b",
                       results_seen, seen.lcd_mode, seen.current_line,
                       seen.coincidence, seen.vblank_irq, seen.stat_irq,
                       seen.line_render_start, seen.frame_flip);
            end
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 9) == 0)
          stall_left = $urandom_range(1, 5);
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL lcd_mode_timing_and_stat_irq");
        $finish;
      end
    end
  end

  // Register write over the config channel, mirrored into the tracker
  task automatic set_reg(input logic idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lmt_pkg::CFG_LINE_COMPARE)
      lyc_value = value;
    else
      stat_enables = value[3:0];
  endtask

  // Sender holds off until every pending result is back
  task automatic wait_drained();
    do @(negedge clk); while (step_queue.size() != 0 || in_valid || status_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] lyc, input logic [7:0] enables, input int count);
    set_reg(lmt_pkg::CFG_LINE_COMPARE, lyc);
    set_reg(lmt_pkg::CFG_STAT_ENABLES, enables);
    @(negedge clk);
    repeat (count) step_queue.push_back(random_step());
    wait_drained();
  endtask

  // Stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed walk: all interrupt sources on, compare on the reset line
    set_reg(lmt_pkg::CFG_LINE_COMPARE, 8'd144);
    set_reg(lmt_pkg::CFG_STAT_ENABLES, 8'h0F);
    @(negedge clk);
    step_queue.push_back(8'd0);               // first step sees V-blank entry
    repeat (17) step_queue.push_back(8'd255); // through V-blank to line 153
    step_queue.push_back(8'd255);             // wrap to line 0, V-blank -> OAM
    step_queue.push_back(8'd50);              // exactly on transfer boundary
    step_queue.push_back(8'd171);             // last transfer cycle
    step_queue.push_back(8'd1);               // H-blank entry
    step_queue.push_back(8'd203);             // last cycle of the line
    step_queue.push_back(8'd1);               // next line, OAM entry
    step_queue.push_back(8'd255);             // skips transfer, lands in H-blank
    wait_drained();

    // random phases over several register settings
    run_phase(8'd0, 8'h00, 225);
    run_phase(8'd255, 8'hFF, 150);
    run_phase(8'($urandom_range(0, 153)), 8'($urandom_range(0, 15)), 200);
    run_phase(8'd153, 8'h08, 150);
    @(negedge clk);
    quiet = 1'b1;
    run_phase(8'($urandom_range(0, 153)), 8'($urandom_range(0, 15)), 250);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && status_due.size() == 0)
      $display("PASS lcd_mode_timing_and_stat_irq");
    else
      $display("FAIL lcd_mode_timing_and_stat_irq");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lmt_pkg.sv
hw/rtl/lmt_cfg.sv
hw/rtl/lmt_step.sv
hw/rtl/lcd_mode_timing_and_stat_irq.sv
tb/sv/tb.sv
